@@ rtl/nearest_delta_r_matcher_core_defines.svh @@
// assertion macros used by the matcher core
`ifndef NEAREST_DELTA_R_MATCHER_CORE_DEFINES_SVH
`define NEAREST_DELTA_R_MATCHER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define NDR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NDR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ndr_pkg.sv @@
// shared constants and types of the nearest delta-r matcher
package ndr_pkg;

    // table geometry
    localparam int TABLE_CAPACITY = 64;
    localparam int ADDR_W  = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
    localparam int COUNT_W = $clog2(TABLE_CAPACITY + 1);

    // field widths
    localparam int MODE_W  = 2;
    localparam int ETA_W   = 18;
    localparam int PHI_W   = 16;
    localparam int DIST_W  = 38;
    localparam int INDEX_W = 6;
    localparam int DETA_W  = ETA_W + 1;

    // threshold after reset
    localparam logic [DIST_W-1:0] MAX_DR_RESET = 38'd1087849;

    // item modes
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // one stored candidate
    typedef struct packed {
        logic signed [ETA_W-1:0] eta;
        logic signed [PHI_W-1:0] phi;
    } cand_t;

    // one distance word leaving the distance pipeline
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] index;
        logic [DIST_W-1:0] sq_dist;
    } dist_res_t;

endpackage

@@ rtl/ndr_cand_ram.sv @@
// candidate table: one write port, one read port with registered data
module ndr_cand_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ndr_pkg::ADDR_W-1:0] waddr,
    input  ndr_pkg::cand_t            wdata,
    input  logic                      re,
    input  logic [ndr_pkg::ADDR_W-1:0] raddr,
    output ndr_pkg::cand_t            rdata
);

    ndr_pkg::cand_t mem [ndr_pkg::TABLE_CAPACITY];
    ndr_pkg::cand_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ndr_dist_pipe.sv @@
// three-stage squared delta-r pipeline: differences, squares, sum
module ndr_dist_pipe (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [ndr_pkg::ADDR_W-1:0]        in_index,
    input  logic signed [ndr_pkg::ETA_W-1:0]  q_eta,
    input  logic signed [ndr_pkg::PHI_W-1:0]  q_phi,
    input  ndr_pkg::cand_t                    cand,
    output ndr_pkg::dist_res_t                dout,
    output logic                              busy
);

    logic                               v1_reg, v2_reg, v3_reg;
    logic [ndr_pkg::ADDR_W-1:0]         idx1_reg, idx2_reg, idx3_reg;
    logic signed [ndr_pkg::DETA_W-1:0]  deta_reg;
    logic signed [ndr_pkg::PHI_W-1:0]   dphi_reg;
    logic signed [ndr_pkg::DIST_W-1:0]  sq_eta_reg;
    logic signed [2*ndr_pkg::PHI_W-1:0] sq_phi_reg;
    logic [ndr_pkg::DIST_W-1:0]         sum_reg;

    logic signed [ndr_pkg::DETA_W-1:0]  deta_next;
    logic signed [ndr_pkg::PHI_W-1:0]   dphi_next;
    logic signed [ndr_pkg::DIST_W-1:0]  sq_eta_next;
    logic signed [2*ndr_pkg::PHI_W-1:0] sq_phi_next;
    logic [ndr_pkg::DIST_W-1:0]         sum_next;

    // differences; phi wraps round the circle in 16 bits
    always_comb
    begin
        deta_next = {q_eta[ndr_pkg::ETA_W-1], q_eta}
                  - {cand.eta[ndr_pkg::ETA_W-1], cand.eta};
        dphi_next = q_phi - cand.phi;
    end

    // squares of the registered differences
    always_comb
    begin
        sq_eta_next = deta_reg * deta_reg;
        sq_phi_next = dphi_reg * dphi_reg;
    end

    // sum of squares, both non-negative
    assign sum_next = ndr_pkg::DIST_W'($unsigned(sq_eta_reg))
                    + ndr_pkg::DIST_W'($unsigned(sq_phi_reg));

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        idx1_reg   <= in_index;
        deta_reg   <= deta_next;
        dphi_reg   <= dphi_next;
        idx2_reg   <= idx1_reg;
        sq_eta_reg <= sq_eta_next;
        sq_phi_reg <= sq_phi_next;
        idx3_reg   <= idx2_reg;
        sum_reg    <= sum_next;
    end

    assign dout.valid   = v3_reg;
    assign dout.index   = idx3_reg;
    assign dout.sq_dist = sum_reg;
    assign busy         = v1_reg | v2_reg | v3_reg;

endmodule

@@ rtl/nearest_delta_r_matcher_core.sv @@
// top level of the nearest delta-r matcher: command decode, table scan, best tracking
//
// Load and clear words never raise busy; a load into a full table is dropped. A query
// raises busy and scans the stored candidates (up to 64) one per cycle through the
// single read port of the candidate table. Each read passes through the registered
// table read, the three distance pipeline stages and the update of the best entry;
// once the scan has drained, the threshold is applied and the result registered with
// the strobe (an empty table gives the strobe without any reads). The result word is on
// found, match_index and distance_squared for the single cycle that strobe is high and
// cannot be held off; busy is already low in that cycle, so the next command may be
// taken alongside it. The threshold register may be written while busy is low.
module nearest_delta_r_matcher_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ndr_pkg::MODE_W-1:0]        mode,
    input  logic signed [ndr_pkg::ETA_W-1:0]  eta,
    input  logic signed [ndr_pkg::PHI_W-1:0]  phi,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ndr_pkg::DIST_W-1:0]        max_dr_squared,
    output logic                              strobe,
    output logic                              found,
    output logic [ndr_pkg::INDEX_W-1:0]       match_index,
    output logic [ndr_pkg::DIST_W-1:0]        distance_squared
);

    `include "nearest_delta_r_matcher_core_defines.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                               state_reg, state_next;
    logic [ndr_pkg::COUNT_W-1:0]        count_reg;
    logic [ndr_pkg::COUNT_W-1:0]        issue_reg;
    logic                               rd_valid_reg;
    logic [ndr_pkg::ADDR_W-1:0]         rd_idx_reg;
    logic signed [ndr_pkg::ETA_W-1:0]   q_eta_reg;
    logic signed [ndr_pkg::PHI_W-1:0]   q_phi_reg;
    logic [ndr_pkg::DIST_W-1:0]         max_dr_reg;
    logic                               have_reg;
    logic [ndr_pkg::ADDR_W-1:0]         best_idx_reg;
    logic [ndr_pkg::DIST_W-1:0]         best_d_reg;
    logic                               strobe_reg;
    logic                               found_reg;
    logic [ndr_pkg::INDEX_W-1:0]        index_reg;
    logic [ndr_pkg::DIST_W-1:0]         dist_reg;

    logic                               accept;
    logic                               table_full;
    logic                               mem_we;
    logic                               issue;
    logic                               drained;
    logic                               in_thr;
    logic                               better;
    ndr_pkg::cand_t                     wr_cand;
    ndr_pkg::cand_t                     rd_cand;
    ndr_pkg::dist_res_t                 dres;
    logic                               pipe_busy;

    // command decode
    assign accept     = start & ~busy;
    assign table_full = (count_reg >= ndr_pkg::COUNT_W'(ndr_pkg::TABLE_CAPACITY));
    assign mem_we     = accept && (mode == ndr_pkg::MODE_LOAD) && !table_full;
    assign wr_cand    = '{eta: eta, phi: phi};

    // scan control
    assign issue   = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign drained = (state_reg == ST_SCAN) && !issue && !rd_valid_reg && !pipe_busy;
    assign better  = dres.valid && (!have_reg || (dres.sq_dist < best_d_reg));
    assign in_thr  = have_reg && (best_d_reg <= max_dr_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == ndr_pkg::MODE_QUERY))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (drained)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // candidate table
    ndr_cand_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[ndr_pkg::ADDR_W-1:0]),
        .wdata (wr_cand),
        .re    (issue),
        .raddr (issue_reg[ndr_pkg::ADDR_W-1:0]),
        .rdata (rd_cand)
    );

    // distance pipeline
    ndr_dist_pipe u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .in_index (rd_idx_reg),
        .q_eta    (q_eta_reg),
        .q_phi    (q_phi_reg),
        .cand     (rd_cand),
        .dout     (dres),
        .busy     (pipe_busy)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            max_dr_reg   <= ndr_pkg::MAX_DR_RESET;
            have_reg     <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            strobe_reg   <= drained;

            // table fill count
            if (mem_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (accept && (mode == ndr_pkg::MODE_CLEAR))
            begin
                count_reg <= '0;
            end

            // read address sequence
            if (accept)
            begin
                issue_reg <= '0;
            end
            else if (issue)
            begin
                issue_reg <= issue_reg + 1'b1;
            end

            // best-so-far flag
            if (accept)
            begin
                have_reg <= 1'b0;
            end
            else if (better)
            begin
                have_reg <= 1'b1;
            end

            // threshold register
            if (cfg_valid && cfg_ready)
            begin
                max_dr_reg <= max_dr_squared;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= issue_reg[ndr_pkg::ADDR_W-1:0];
        if (accept)
        begin
            q_eta_reg <= eta;
            q_phi_reg <= phi;
        end
        if (better)
        begin
            best_idx_reg <= dres.index;
            best_d_reg   <= dres.sq_dist;
        end
        if (drained)
        begin
            found_reg <= in_thr;
            index_reg <= in_thr ? ndr_pkg::INDEX_W'(best_idx_reg) : '0;
            dist_reg  <= in_thr ? best_d_reg : '0;
        end
    end

    assign busy             = (state_reg != ST_IDLE);
    assign cfg_ready        = ~busy;
    assign strobe           = strobe_reg;
    assign found            = found_reg;
    assign match_index      = index_reg;
    assign distance_squared = dist_reg;

    // checks
    `NDR_ASSERT_IMP(a_dist_only_in_scan, dres.valid, state_reg == ST_SCAN, "distance word outside a scan")
    `NDR_ASSERT_NXT(a_strobe_after_scan, drained, strobe && (state_reg == ST_IDLE), "scan end without result strobe")
    `NDR_ASSERT_IMP(a_found_within, strobe && found, distance_squared <= max_dr_reg, "match beyond threshold")
    `NDR_ASSERT_IMP(a_miss_zeroed, strobe && !found, (match_index == '0) && (distance_squared == '0), "miss word not zeroed")
    `NDR_ASSERT_IMP(a_no_load_in_scan, busy, !mem_we && (count_reg <= ndr_pkg::COUNT_W'(ndr_pkg::TABLE_CAPACITY)), "table written during scan")

endmodule
